[rtl/core/gpf_pkg.sv]
`default_nettype none
package gpf_pkg;

  localparam int MAX_OBJECTS_DEF = 1024;
  localparam int SQ_STAGES = 33;
  localparam int DIV_STAGES = 48;
  localparam int DEN_W = 108;

  localparam logic [2:0] CFG_GRAVITY = 3'd0;
  localparam logic [2:0] CFG_SRC_X   = 3'd1;
  localparam logic [2:0] CFG_SRC_Y   = 3'd2;
  localparam logic [2:0] CFG_SRC_M   = 3'd3;
  localparam logic [2:0] CFG_SRC_IDX = 3'd4;
  localparam logic [2:0] CFG_OBJ_CNT = 3'd5;

  localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

  typedef struct packed {
    logic [9:0]  idx;
    logic        negx;
    logic        negy;
    logic        ok;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [95:0] p;
    logic [65:0] s;
  } sqsb_t;

  typedef struct packed {
    logic [9:0] idx;
    logic       negx;
    logic       negy;
    logic       ok;
    logic       satx;
    logic       saty;
  } divsb_t;

  typedef struct packed {
    logic [DEN_W-1:0] r;
    logic [47:0]      lo;
    logic [47:0]      q;
  } lane_t;

  // one restoring division step
  function automatic lane_t div_step(lane_t a, logic [DEN_W-1:0] d);
    lane_t b;
    logic [DEN_W:0] t;
    t = {a.r, a.lo[47]};
    b.lo = {a.lo[46:0], 1'b0};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      b.q = {a.q[46:0], 1'b1};
    end else begin
      b.q = {a.q[46:0], 1'b0};
    end
    b.r = t[DEN_W-1:0];
    return b;
  endfunction

endpackage
`default_nettype wire

[rtl/core/gravity_pair_force.sv]
// Accepts one request per cycle while in_stall is low; the pipeline holds while it is high.
// Datapath: a 33-stage square-root pipeline and a 48-stage restoring divider, one bit per stage.
// Output register plus skid stage; in_stall is registered and rises only while the skid is full.
// Reset (rst, synchronous): pipeline emptied, gravity_constant = 1.0, config registers 0.
`default_nettype none
module gravity_pair_force #(
  parameter int MAX_OBJECTS = gpf_pkg::MAX_OBJECTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [9:0]  obj_index,
  input  wire logic signed [31:0] obj_x,
  input  wire logic signed [31:0] obj_y,
  input  wire logic [31:0] obj_mass,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_index,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic             applied,
  output logic             saturated
);
  localparam int CLOG = $clog2(MAX_OBJECTS + 1);
  localparam int CW = (CLOG > 11) ? CLOG : 11;

  typedef struct packed {
    logic [9:0]  idx;
    logic [47:0] fx;
    logic [47:0] fy;
    logic        app;
    logic        sat;
  } res_t;

  logic [31:0] grav, src_x, src_y, src_m;
  logic [9:0]  src_idx;
  logic [10:0] obj_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav    <= 32'd16777216;
      src_x   <= '0;
      src_y   <= '0;
      src_m   <= '0;
      src_idx <= '0;
      obj_cnt <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpf_pkg::CFG_GRAVITY: grav    <= cfg_data;
        gpf_pkg::CFG_SRC_X:   src_x   <= cfg_data;
        gpf_pkg::CFG_SRC_Y:   src_y   <= cfg_data;
        gpf_pkg::CFG_SRC_M:   src_m   <= cfg_data;
        gpf_pkg::CFG_SRC_IDX: src_idx <= cfg_data[9:0];
        gpf_pkg::CFG_OBJ_CNT: obj_cnt <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v, oreg_v;
  res_t skid_d, oreg_d;

  assign en       = !skid_v;
  assign in_stall = skid_v;

  // front end
  logic [CW-1:0] cnt_ext, cnt;
  logic [32:0]   dx, dy;
  assign cnt_ext = CW'(obj_cnt);
  assign cnt = (cnt_ext < CW'(MAX_OBJECTS)) ? cnt_ext : CW'(MAX_OBJECTS);
  assign dx = {src_x[31], src_x} - {obj_x[31], obj_x};
  assign dy = {src_y[31], src_y} - {obj_y[31], obj_y};

  logic        v1, v2, v3, v4;
  logic [9:0]  idx1, idx2, idx3;
  logic        nx1, ny1, nx2, ny2, nx3, ny3;
  logic        ok1, ok2, ok3;
  logic [32:0] ax1, ay1, ax2, ay2, ax3, ay3;
  logic [31:0] mi1;
  logic [65:0] sqx2, sqy2, s3;
  logic [63:0] pm2, pgl3, pgh3;
  logic        nz2;
  gpf_pkg::sqsb_t sb4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= obj_index;
      nx1  <= dx[32];
      ny1  <= dy[32];
      ax1  <= dx[32] ? -dx : dx;
      ay1  <= dy[32] ? -dy : dy;
      mi1  <= obj_mass;
      ok1  <= (CW'(src_idx) < cnt) && (CW'(obj_index) < cnt) && (obj_index != src_idx);

      idx2 <= idx1;
      nx2  <= nx1;
      ny2  <= ny1;
      ax2  <= ax1;
      ay2  <= ay1;
      ok2  <= ok1;
      sqx2 <= ax1 * ax1;
      sqy2 <= ay1 * ay1;
      pm2  <= src_m * mi1;
      nz2  <= |{ax1, ay1};

      idx3 <= idx2;
      nx3  <= nx2;
      ny3  <= ny2;
      ax3  <= ax2;
      ay3  <= ay2;
      ok3  <= ok2 & nz2;
      s3   <= sqx2 + sqy2;
      pgl3 <= pm2[31:0] * grav;
      pgh3 <= pm2[63:32] * grav;

      sb4.idx  <= idx3;
      sb4.negx <= nx3;
      sb4.negy <= ny3;
      sb4.ok   <= ok3;
      sb4.ax   <= ax3;
      sb4.ay   <= ay3;
      sb4.p    <= {32'd0, pgl3} + {pgh3, 32'd0};
      sb4.s    <= s3;
    end
  end

  logic           rv;
  logic [32:0]    root;
  gpf_pkg::sqsb_t rsb;

  gpf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .in_rad   (sb4.s),
    .in_sb    (sb4),
    .out_valid(rv),
    .out_root (root),
    .out_sb   (rsb)
  );

  // denominator and numerators
  logic        va, vb, vc;
  logic [9:0]  idxa, idxb;
  logic        nxa, nya, oka, nxb, nyb, okb;
  logic [65:0] sml, smh;
  logic [64:0] px0, px1, px2, py0, py1, py2;
  logic [gpf_pkg::DEN_W-1:0] denb, denc;
  logic [127:0] numx, numy;
  logic [98:0]  sm_sum;
  gpf_pkg::lane_t  lxc, lyc;
  gpf_pkg::divsb_t sbc;

  assign sm_sum = {smh, 33'd0} + {33'd0, sml};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= rv;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idxa <= rsb.idx;
      nxa  <= rsb.negx;
      nya  <= rsb.negy;
      oka  <= rsb.ok;
      sml  <= rsb.s[32:0] * root;
      smh  <= rsb.s[65:33] * root;
      px0  <= rsb.p[31:0] * rsb.ax;
      px1  <= rsb.p[63:32] * rsb.ax;
      px2  <= rsb.p[95:64] * rsb.ax;
      py0  <= rsb.p[31:0] * rsb.ay;
      py1  <= rsb.p[63:32] * rsb.ay;
      py2  <= rsb.p[95:64] * rsb.ay;

      idxb <= idxa;
      nxb  <= nxa;
      nyb  <= nya;
      okb  <= oka;
      denb <= {1'b0, sm_sum, 8'd0};
      numx <= (128'(px2) << 64) + (128'(px1) << 32) + 128'(px0);
      numy <= (128'(py2) << 64) + (128'(py1) << 32) + 128'(py0);

      denc      <= denb;
      lxc.r     <= {28'd0, numx[127:48]};
      lxc.lo    <= numx[47:0];
      lxc.q     <= '0;
      lyc.r     <= {28'd0, numy[127:48]};
      lyc.lo    <= numy[47:0];
      lyc.q     <= '0;
      sbc.idx   <= idxb;
      sbc.negx  <= nxb;
      sbc.negy  <= nyb;
      sbc.ok    <= okb;
      sbc.satx  <= {28'd0, numx[127:48]} >= denb;
      sbc.saty  <= {28'd0, numy[127:48]} >= denb;
    end
  end

  logic            dv;
  logic [47:0]     qx, qy;
  gpf_pkg::divsb_t dsb;

  gpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vc),
    .in_den   (denc),
    .in_x     (lxc),
    .in_y     (lyc),
    .in_sb    (sbc),
    .out_valid(dv),
    .out_qx   (qx),
    .out_qy   (qy),
    .out_sb   (dsb)
  );

  // clamp, sign, mask
  logic [47:0] limx, limy, vx, vy;
  logic        fsx, fsy;
  res_t        fin;

  assign limx = dsb.negx ? gpf_pkg::NEG_LIMIT : gpf_pkg::POS_LIMIT;
  assign limy = dsb.negy ? gpf_pkg::NEG_LIMIT : gpf_pkg::POS_LIMIT;
  assign fsx  = dsb.satx | (qx > limx);
  assign fsy  = dsb.saty | (qy > limy);
  assign vx   = fsx ? limx : qx;
  assign vy   = fsy ? limy : qy;

  always_comb begin
    fin.idx = dsb.idx;
    fin.app = dsb.ok;
    fin.fx  = '0;
    fin.fy  = '0;
    fin.sat = 1'b0;
    if (dsb.ok) begin
      fin.fx  = dsb.negx ? (~vx + 48'd1) : vx;
      fin.fy  = dsb.negy ? (~vy + 48'd1) : vy;
      fin.sat = fsx | fsy;
    end
  end

  logic lv;
  res_t ld;

  always_ff @(posedge clk) begin
    if (rst) begin
      lv <= 1'b0;
    end else if (en) begin
      lv <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld <= fin;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      oreg_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (!out_stall) begin
        skid_v <= 1'b0;
      end
    end else if (lv) begin
      if (oreg_v && out_stall) begin
        skid_v <= 1'b1;
      end else begin
        oreg_v <= 1'b1;
      end
    end else if (!out_stall) begin
      oreg_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (!out_stall) begin
        oreg_d <= skid_d;
      end
    end else if (lv) begin
      if (oreg_v && out_stall) begin
        skid_d <= ld;
      end else begin
        oreg_d <= ld;
      end
    end
  end

  assign out_valid = oreg_v;
  assign out_index = oreg_d.idx;
  assign force_x   = oreg_d.fx;
  assign force_y   = oreg_d.fy;
  assign applied   = oreg_d.app;
  assign saturated = oreg_d.sat;
endmodule
`default_nettype wire

[rtl/core/gpf_sqrt.sv]
`default_nettype none
module gpf_sqrt (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [65:0]   in_rad,
  input  wire gpf_pkg::sqsb_t in_sb,
  output logic               out_valid,
  output logic [32:0]        out_root,
  output gpf_pkg::sqsb_t     out_sb
);
  localparam int N = gpf_pkg::SQ_STAGES;

  logic           v  [0:N-1];
  logic [66:0]    op [0:N-1];
  logic [66:0]    rs [0:N-1];
  gpf_pkg::sqsb_t sb [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [66:0] ONE = 67'(1) << (2 * (N - 1 - k));
    logic           vi;
    logic [66:0]    oi;
    logic [66:0]    ri;
    logic [66:0]    trial;
    gpf_pkg::sqsb_t si;
    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign oi = {1'b0, in_rad};
      assign ri = '0;
      assign si = in_sb;
    end else begin : g_next
      assign vi = v[k-1];
      assign oi = op[k-1];
      assign ri = rs[k-1];
      assign si = sb[k-1];
    end
    assign trial = ri + ONE;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (oi >= trial) begin
          op[k] <= oi - trial;
          rs[k] <= (ri >> 1) + ONE;
        end else begin
          op[k] <= oi;
          rs[k] <= ri >> 1;
        end
        sb[k] <= si;
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_root  = rs[N-1][32:0];
  assign out_sb    = sb[N-1];
endmodule
`default_nettype wire

[rtl/core/gpf_div.sv]
`default_nettype none
module gpf_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [gpf_pkg::DEN_W-1:0] in_den,
  input  wire gpf_pkg::lane_t            in_x,
  input  wire gpf_pkg::lane_t            in_y,
  input  wire gpf_pkg::divsb_t           in_sb,
  output logic                           out_valid,
  output logic [47:0]                    out_qx,
  output logic [47:0]                    out_qy,
  output gpf_pkg::divsb_t                out_sb
);
  localparam int N = gpf_pkg::DIV_STAGES;

  logic                      v  [0:N-1];
  logic [gpf_pkg::DEN_W-1:0] dn [0:N-1];
  gpf_pkg::lane_t            lx [0:N-1];
  gpf_pkg::lane_t            ly [0:N-1];
  gpf_pkg::divsb_t           sb [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                      vi;
    logic [gpf_pkg::DEN_W-1:0] di;
    gpf_pkg::lane_t            xi;
    gpf_pkg::lane_t            yi;
    gpf_pkg::divsb_t           si;
    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign di = in_den;
      assign xi = in_x;
      assign yi = in_y;
      assign si = in_sb;
    end else begin : g_next
      assign vi = v[k-1];
      assign di = dn[k-1];
      assign xi = lx[k-1];
      assign yi = ly[k-1];
      assign si = sb[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dn[k] <= di;
        lx[k] <= gpf_pkg::div_step(xi, di);
        ly[k] <= gpf_pkg::div_step(yi, di);
        sb[k] <= si;
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_qx    = lx[N-1].q;
  assign out_qy    = ly[N-1].q;
  assign out_sb    = sb[N-1];
endmodule
`default_nettype wire
